>>> design/fapm_pkg.sv
`timescale 1ns / 1ps

package fapm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int PAT_AW      = $clog2(MAX_PATTERN);
  localparam int STATE_W     = $clog2(MAX_PATTERN + 1);
  localparam int FAIL_DEPTH  = MAX_PATTERN + 1;
  localparam int LEN_W       = 7;
  localparam int REQ_W       = 2;
  localparam int IDX_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);

  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_TEXT,
    KIND_RESTART,
    KIND_NOP
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RB_INIT,
    ST_RB_FETCH,
    ST_WALK
  } st_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } item_t;

endpackage

>>> design/finite_automaton_pattern_matcher.sv
`timescale 1ns / 1ps

// Exact byte-pattern search over a text stream, one result item per input item.
// The search is run as a prefix automaton: a failure-link table built from the
// stored pattern replaces the full transition table, so each text byte follows
// failure links one at a time (at most the current match depth), paced by the
// single read port of the pattern and link memories. Load, restart and unused
// request items are answered straight from the idle state. The first text byte
// after reset, a pattern load or a length write first rebuilds the link table,
// fetching each pattern byte and following links (the link steps of the
// rebuild are bounded by the length). A two-entry input queue lets the stream
// keep moving while the back end works; results wait in an output register.
module finite_automaton_pattern_matcher import fapm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,     // pattern_length
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,    // [5:0] pattern_index, [13:6] data_byte
  input  logic [REQ_W-1:0]  s_axis_tuser,    // [1:0] req_type
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,    // [31:0] match_start, [63:32] match_count
  output logic              m_axis_tuser     // [0] match_found
);

  logic              item_valid;
  item_t             item;
  logic              item_pop;
  logic [WORD_W-1:0] match_start;
  logic [WORD_W-1:0] match_count;

  fapm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .req_type_i      (s_axis_tuser),
    .pattern_index_i (s_axis_tdata[IDX_W-1:0]),
    .data_byte_i     (s_axis_tdata[IDX_W+BYTE_W-1:IDX_W]),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_pop_i      (item_pop)
  );

  fapm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .match_found_o (m_axis_tuser),
    .match_start_o (match_start),
    .match_count_o (match_count)
  );

  assign m_axis_tdata = {match_count, match_start};

endmodule

>>> design/fapm_ram.sv
`timescale 1ns / 1ps

module fapm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/fapm_front.sv
`timescale 1ns / 1ps

module fapm_front import fapm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [IDX_W-1:0]  pattern_index_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              item_valid_o,
  output item_t             item_o,
  input  logic              item_pop_i
);

  item_t           buf_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0] cnt_q, cnt_d;
  item_t           new_item;
  logic            push;
  logic            pop;

  always_comb begin
    case (req_type_i)
      REQ_LOAD:    new_item.kind = KIND_LOAD;
      REQ_TEXT:    new_item.kind = KIND_TEXT;
      REQ_RESTART: new_item.kind = KIND_RESTART;
      default:     new_item.kind = KIND_NOP;
    endcase
    new_item.idx  = pattern_index_i;
    new_item.data = data_byte_i;
  end

  assign in_ready_o   = (cnt_q != Q_CW'(Q_DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

>>> design/fapm_back.sv
`timescale 1ns / 1ps

module fapm_back import fapm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  input  logic              item_valid_i,
  input  item_t             item_i,
  output logic              item_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              match_found_o,
  output logic [WORD_W-1:0] match_start_o,
  output logic [WORD_W-1:0] match_count_o
);

  st_e                state_q, state_d;
  logic               rb_q, rb_d;         // walk belongs to the failure-table rebuild
  logic               dirty_q, dirty_d;   // failure table stale
  logic [LEN_W-1:0]   len_q, len_d;
  logic [STATE_W-1:0] mstate_q, mstate_d;
  logic [WORD_W-1:0]  pos_q, pos_d;
  logic [WORD_W-1:0]  cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;

  logic [STATE_W-1:0] k_q, k_d;
  logic [STATE_W-1:0] q_q, q_d;
  logic [BYTE_W-1:0]  c_q, c_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic               out_found_q, out_found_d;
  logic [WORD_W-1:0]  out_start_q, out_start_d;
  logic [WORD_W-1:0]  out_count_q, out_count_d;

  logic [STATE_W-1:0] m;
  logic [STATE_W-1:0] rd_addr;
  logic               p_we;
  logic [BYTE_W-1:0]  p_rdata;
  logic               pi_we;
  logic [STATE_W-1:0] pi_waddr;
  logic [STATE_W-1:0] pi_wdata;
  logic [STATE_W-1:0] pi_rdata;
  logic               slot_free;
  logic               hit;
  logic [STATE_W-1:0] res;
  logic [WORD_W-1:0]  cnt_inc;

  always_comb begin
    if (len_q == '0) begin
      m = STATE_W'(1);
    end else if (len_q > LEN_W'(MAX_PATTERN)) begin
      m = STATE_W'(MAX_PATTERN);
    end else begin
      m = STATE_W'(len_q);
    end
  end

  fapm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PATTERN)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (item_i.idx[PAT_AW-1:0]),
    .wdata_i (item_i.data),
    .raddr_i (rd_addr[PAT_AW-1:0]),
    .rdata_o (p_rdata)
  );

  // failure links, entry q is the longest proper border of the first q bytes
  fapm_ram #(
    .WIDTH (STATE_W),
    .DEPTH (FAIL_DEPTH)
  ) u_fail_ram (
    .clk_i   (clk_i),
    .we_i    (pi_we),
    .waddr_i (pi_waddr),
    .wdata_i (pi_wdata),
    .raddr_i (rd_addr),
    .rdata_o (pi_rdata)
  );

  assign slot_free = !out_valid_q || out_ready_i;
  assign hit       = (k_q < m) && (p_rdata == c_q);
  assign res       = hit ? k_q + 1'b1 : '0;
  assign cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    rb_d        = rb_q;
    dirty_d     = dirty_q;
    len_d       = len_q;
    mstate_d    = mstate_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    k_d         = k_q;
    q_d         = q_q;
    c_d         = c_q;
    byte_d      = byte_q;
    out_found_d = out_found_q;
    out_start_d = out_start_q;
    out_count_d = out_count_q;
    rd_addr     = k_q;
    p_we        = 1'b0;
    pi_we       = 1'b0;
    pi_waddr    = q_q;
    pi_wdata    = res;
    item_pop_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i && slot_free) begin
          item_pop_o = 1'b1;
          case (item_i.kind)
            KIND_LOAD: begin
              p_we        = (STATE_W'(item_i.idx) < STATE_W'(MAX_PATTERN));
              mstate_d    = '0;
              dirty_d     = 1'b1;
              out_valid_d = 1'b1;
              out_found_d = 1'b0;
              out_start_d = '0;
              out_count_d = cnt_q;
            end
            KIND_TEXT: begin
              byte_d = item_i.data;
              if (dirty_q) begin
                state_d = ST_RB_INIT;
              end else begin
                k_d     = mstate_q;
                c_d     = item_i.data;
                rb_d    = 1'b0;
                rd_addr = mstate_q;
                state_d = ST_WALK;
              end
            end
            KIND_RESTART: begin
              mstate_d    = '0;
              pos_d       = '0;
              cnt_d       = '0;
              out_valid_d = 1'b1;
              out_found_d = 1'b0;
              out_start_d = '0;
              out_count_d = '0;
            end
            default: begin
              out_valid_d = 1'b1;
              out_found_d = 1'b0;
              out_start_d = '0;
              out_count_d = cnt_q;
            end
          endcase
        end
      end

      ST_RB_INIT: begin
        pi_we    = 1'b1;
        pi_waddr = STATE_W'(1);
        pi_wdata = '0;
        k_d      = '0;
        q_d      = STATE_W'(2);
        if (m == STATE_W'(1)) begin
          dirty_d = 1'b0;
          k_d     = mstate_q;
          c_d     = byte_q;
          rb_d    = 1'b0;
          rd_addr = mstate_q;
          state_d = ST_WALK;
        end else begin
          rb_d    = 1'b1;
          rd_addr = STATE_W'(1);
          state_d = ST_RB_FETCH;
        end
      end

      ST_RB_FETCH: begin
        c_d     = p_rdata;
        rd_addr = k_q;
        state_d = ST_WALK;
      end

      ST_WALK: begin
        if (hit || (k_q == '0)) begin
          if (rb_q) begin
            pi_we = 1'b1;
            k_d   = res;
            if (q_q == m) begin
              // table complete; the match state is zero after any rebuild cause
              dirty_d = 1'b0;
              k_d     = mstate_q;
              c_d     = byte_q;
              rb_d    = 1'b0;
              rd_addr = mstate_q;
            end else begin
              q_d     = q_q + 1'b1;
              rd_addr = q_q;
              state_d = ST_RB_FETCH;
            end
          end else begin
            mstate_d    = res;
            pos_d       = pos_q + 1'b1;
            out_valid_d = 1'b1;
            if (res == m) begin
              cnt_d       = cnt_inc;
              out_found_d = 1'b1;
              out_start_d = pos_q - WORD_W'(m) + 1'b1;
              out_count_d = cnt_inc;
            end else begin
              out_found_d = 1'b0;
              out_start_d = '0;
              out_count_d = cnt_q;
            end
            state_d = ST_IDLE;
          end
        end else begin
          // mismatch: follow the failure link
          k_d     = pi_rdata;
          rd_addr = pi_rdata;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      len_d    = cfg_wdata_i;
      mstate_d = '0;
      dirty_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rb_q        <= 1'b0;
      dirty_q     <= 1'b1;
      len_q       <= LEN_W'(1);
      mstate_q    <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rb_q        <= rb_d;
      dirty_q     <= dirty_d;
      len_q       <= len_d;
      mstate_q    <= mstate_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    q_q         <= q_d;
    c_q         <= c_d;
    byte_q      <= byte_d;
    out_found_q <= out_found_d;
    out_start_q <= out_start_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign match_found_o = out_found_q;
  assign match_start_o = out_start_q;
  assign match_count_o = out_count_q;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench import fapm_pkg::*; ();

  localparam int LIMIT_NS      = 3_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 225;
  localparam int NUM_PHASES    = 8;
  localparam logic [REQ_W-1:0] REQ_UNUSED = KIND_NOP;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] count;
  } match_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;   // [5:0] pattern_index, [13:6] data_byte
  logic [REQ_W-1:0]  s_axis_tuser  = '0;   // [1:0] req_type
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [63:0]       m_axis_tdata;         // [31:0] match_start, [63:32] match_count
  logic              m_axis_tuser;         // [0] match_found

  // predictor state
  logic [BYTE_W-1:0] pat_mem [MAX_PATTERN];
  logic [LEN_W-1:0]  len_reg     = 7'd1;
  int                automaton_q = 0;
  logic [WORD_W-1:0] text_pos    = '0;
  logic [WORD_W-1:0] hit_count   = '0;
  match_result_t     expected_matches [$];

  int send_idle_pct   = 0;
  int rx_stall_pct    = 0;
  int hold_off_cycles = 0;
  int mismatch_count  = 0;
  int items_sent      = 0;
  int text_items      = 0;
  int results_seen    = 0;
  int matches_seen    = 0;
  int lengths_used    = 1;

  logic [BYTE_W-1:0] alpha_base = 8'h61;
  int                alpha_size = 2;

  finite_automaton_pattern_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic int active_len();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_PATTERN) return MAX_PATTERN;
    return int'(len_reg);
  endfunction

  // longest pattern prefix that is a suffix of (prefix of length q) followed by c
  function automatic int advance_automaton(int q, int m, logic [BYTE_W-1:0] c);
    bit ok;
    if (q > m) q = m;
    for (int k = (q < m) ? q + 1 : q; k > 0; k--) begin
      ok = (pat_mem[k-1] == c);
      for (int i = 0; ok && i < k - 1; i++)
        ok = (pat_mem[i] == pat_mem[q - k + 1 + i]);
      if (ok) return k;
    end
    return 0;
  endfunction

  function automatic void predict_match_result(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                               logic [BYTE_W-1:0] b);
    match_result_t r;
    int m;
    r = '0;
    case (req)
      REQ_LOAD: begin
        pat_mem[idx] = b;
        automaton_q  = 0;
      end
      REQ_TEXT: begin
        m = active_len();
        automaton_q = advance_automaton(automaton_q, m, b);
        if (automaton_q == m) begin
          r.found = 1'b1;
          r.start = text_pos - WORD_W'(m) + 1;
          if (hit_count != '1) hit_count++;
        end
        text_pos++;
      end
      REQ_RESTART: begin
        automaton_q = 0;
        text_pos    = '0;
        hit_count   = '0;
      end
      default: ;
    endcase
    r.count = hit_count;
    expected_matches.insert(expected_matches.size(), r);
  endfunction

  function automatic void report_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endfunction

  task automatic check_match_result();
    match_result_t got;
    match_result_t want;
    got.found = m_axis_tuser;
    got.start = m_axis_tdata[31:0];
    got.count = m_axis_tdata[63:32];
    results_seen++;
    if (got.found === 1'b1) matches_seen++;
    if (expected_matches.size() == 0) begin
      report_failure($sformatf("unexpected result item: found=%0b start=%0d count=%0d",
                               got.found, got.start, got.count));
    end else begin
      want = expected_matches.pop_front();
      if (got.found !== want.found || got.start !== want.start || got.count !== want.count)
        report_failure($sformatf(
          "result %0d: expected found=%0b start=%0d count=%0d, got found=%0b start=%0d count=%0d",
          results_seen, want.found, want.start, want.count, got.found, got.start, got.count));
    end
  endtask

  // result side: check, then decide ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_match_result();
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // tvalid is only lowered when a gap is taken, so back-to-back items keep it high
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {2'b00, b, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_match_result(req, idx, b);
    items_sent++;
    if (req == REQ_TEXT) text_items++;
  endtask

  task automatic send_text(input logic [BYTE_W-1:0] b);
    send_item(REQ_TEXT, IDX_W'($urandom_range(63)), b);
  endtask

  function automatic logic [BYTE_W-1:0] alpha_byte();
    return alpha_base + BYTE_W'($urandom_range(alpha_size - 1));
  endfunction

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_pattern_length(input logic [LEN_W-1:0] v);
    wait_results_drained();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    len_reg     = v;
    automaton_q = 0;
    lengths_used++;
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    rx_stall_pct  = stall_pct;
  endtask

  task automatic test_directed_cases();
    set_idling(0, 0);
    // length 1 after reset
    send_item(REQ_UNUSED, 6'h2A, 8'hC3);
    send_item(REQ_LOAD, 6'd0, 8'hFF);
    send_text(8'hFF);
    send_text(8'h00);
    send_text(8'hFF);
    send_item(REQ_RESTART, '1, '0);
    send_text(8'hFF);

    set_pattern_length(7'd3);
    send_item(REQ_LOAD, 6'd0, 8'h61);
    send_item(REQ_LOAD, 6'd1, 8'h62);
    send_item(REQ_LOAD, 6'd2, 8'h61);
    send_item(REQ_LOAD, 6'd63, 8'h00);
    // overlapping occurrences of "aba"
    send_text(8'h61);
    send_text(8'h62);
    send_text(8'h61);
    send_text(8'h62);
    send_text(8'h61);
    // unused kind leaves the automaton where it was
    send_text(8'h61);
    send_text(8'h62);
    send_item(REQ_UNUSED, 6'd0, 8'hFF);
    send_text(8'h61);
    // a load restarts the automaton mid-match
    send_text(8'h61);
    send_text(8'h62);
    send_item(REQ_LOAD, 6'd5, 8'h7A);
    send_text(8'h61);
    wait_results_drained();
  endtask

  task automatic test_output_backpressure();
    set_idling(0, 0);
    hold_off_cycles = 300;
    repeat (24) send_text(8'h61 + BYTE_W'($urandom_range(1)));
    wait_results_drained();
  endtask

  function automatic logic [LEN_W-1:0] phase_length(int p);
    case (p)
      0:       return 7'd1;
      1:       return 7'd64;
      2:       return 7'd3;
      3:       return 7'd0;
      4:       return 7'd127;
      5:       return 7'd5;
      6:       return 7'd2;
      default: return LEN_W'($urandom_range(4, 9));
    endcase
  endfunction

  task automatic test_random_search();
    int n;
    int m;
    int pick;
    int cut;
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_pattern_length(phase_length(p));
      case (p % 4)
        0:       set_idling(0, 0);
        1:       set_idling(62, 0);
        2:       set_idling(0, 62);
        default: set_idling(31, 31);
      endcase
      alpha_base = BYTE_W'($urandom_range(252));
      alpha_size = $urandom_range(2, 4);
      m = active_len();
      // every entry the length reaches is written before any text item
      for (int i = 0; i < m; i++) send_item(REQ_LOAD, IDX_W'(i), alpha_byte());
      n = m;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          send_text(alpha_byte());
          n++;
        end else if (pick < 72) begin
          for (int i = 0; i < m; i++) send_text(pat_mem[i]);
          n += m;
        end else if (pick < 82) begin
          cut = $urandom_range(m - 1);
          for (int i = 0; i < cut; i++) send_text(pat_mem[i]);
          send_text(alpha_byte());
          n += cut + 1;
        end else if (pick < 87) begin
          send_item(REQ_RESTART, IDX_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
          n++;
        end else if (pick < 93) begin
          send_item(REQ_LOAD, IDX_W'($urandom_range(63)),
                    $urandom_range(1) ? alpha_byte() : BYTE_W'($urandom_range(255)));
          n++;
        end else if (pick < 96) begin
          send_item(REQ_UNUSED, IDX_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
        end else begin
          send_text(BYTE_W'($urandom_range(255)));
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_output_backpressure();
    test_random_search();
    wait_results_drained();
    $display("Sent %0d items (%0d text bytes) across %0d length settings and all idle modes",
             items_sent, text_items, lengths_used);
    $display("Checked %0d results, %0d of them matches; %0d mismatches",
             results_seen, matches_seen, mismatch_count);
    if (mismatch_count == 0 && expected_matches.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
